FILE: rtl/cfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared operation and status codes for the complex fixed-point ALU.
// ----------------------------------------------------------------------------
package cfa_pkg;

  // operation codes carried with each input beat
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/cfa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_front
// Front pipeline: input register, products, sums, divider setup (4 stages).
// ----------------------------------------------------------------------------
module cfa_front #(
  parameter int DW = 16,
  parameter int F  = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_v,
  input  wire logic [1:0]             in_cmd,
  input  wire logic signed [DW-1:0]   in_a,
  input  wire logic signed [DW-1:0]   in_b,
  input  wire logic signed [DW-1:0]   in_c,
  input  wire logic signed [DW-1:0]   in_d,
  output logic                        out_v,
  output logic [3*DW+F:0]             out_rem_re,
  output logic [3*DW+F:0]             out_rem_im,
  output logic [2*DW-1:0]             out_den,
  output logic [4*DW+8:0]             out_side
);
  localparam int PW  = 2 * DW;
  localparam int SW  = 2 * DW + 1;
  localparam int XW  = 3 * DW + F + 1;

  // stage 1: input register
  logic                  v1;
  cfa_pkg::cmd_t         cmd1;
  logic signed [DW-1:0]  a1, b1, c1, d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
    end
    if (en) begin
      cmd1 <= cfa_pkg::cmd_t'(in_cmd);
      a1   <= in_a;
      b1   <= in_b;
      c1   <= in_c;
      d1   <= in_d;
    end
  end

  // stage 2: six products, add/sub result
  logic                  v2;
  cfa_pkg::cmd_t         cmd2;
  logic signed [PW-1:0]  ac, bd, ad, bc, cc, dd;
  logic signed [SW-1:0]  lin2_re, lin2_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      cmd2 <= cmd1;
      ac   <= a1 * c1;
      bd   <= b1 * d1;
      ad   <= a1 * d1;
      bc   <= b1 * c1;
      cc   <= c1 * c1;
      dd   <= d1 * d1;
      if (cmd1 == cfa_pkg::OP_SUB) begin
        lin2_re <= SW'(a1) - SW'(c1);
        lin2_im <= SW'(b1) - SW'(d1);
      end else begin
        lin2_re <= SW'(a1) + SW'(c1);
        lin2_im <= SW'(b1) + SW'(d1);
      end
    end
  end

  // stage 3: product sums, numerator magnitudes, denominator
  logic signed [SW-1:0]  mre, mim, nre, nim;

  always_comb begin
    mre = SW'(ac) - SW'(bd);
    mim = SW'(ad) + SW'(bc);
    nre = SW'(ac) + SW'(bd);
    nim = SW'(bc) - SW'(ad);
  end

  logic                  v3;
  cfa_pkg::cmd_t         cmd3;
  logic signed [SW-1:0]  lin3_re, lin3_im;
  logic [SW-1:0]         mag3_re, mag3_im;
  logic                  neg3_re, neg3_im;
  logic [PW-1:0]         den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      cmd3 <= cmd2;
      if (cmd2 == cfa_pkg::OP_MUL) begin
        lin3_re <= mre >>> F;
        lin3_im <= mim >>> F;
      end else begin
        lin3_re <= lin2_re;
        lin3_im <= lin2_im;
      end
      neg3_re <= nre[SW-1];
      neg3_im <= nim[SW-1];
      mag3_re <= nre[SW-1] ? $unsigned(-nre) : $unsigned(nre);
      mag3_im <= nim[SW-1] ? $unsigned(-nim) : $unsigned(nim);
      den3    <= $unsigned(cc) + $unsigned(dd);
    end
  end

  // stage 4: scaled dividend and quotient overflow check
  logic [XW-1:0] x_re, x_im, den_top;

  always_comb begin
    x_re    = XW'(mag3_re) << F;
    x_im    = XW'(mag3_im) << F;
    den_top = XW'(den3) << DW;
  end

  logic                  v4;
  cfa_pkg::cmd_t         cmd4;
  logic                  div0, ovf_re, ovf_im, neg4_re, neg4_im;
  logic signed [SW-1:0]  lin4_re, lin4_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      cmd4       <= cmd3;
      div0       <= (den3 == '0);
      ovf_re     <= (x_re >= den_top);
      ovf_im     <= (x_im >= den_top);
      neg4_re    <= neg3_re;
      neg4_im    <= neg3_im;
      lin4_re    <= lin3_re;
      lin4_im    <= lin3_im;
      out_rem_re <= x_re;
      out_rem_im <= x_im;
      out_den    <= den3;
    end
  end

  assign out_v    = v4;
  assign out_side = {cmd4, div0, ovf_re, ovf_im, neg4_re, neg4_im, lin4_re, lin4_im};

endmodule
`default_nettype wire

FILE: rtl/cfa_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_div_stage
// One restoring-division step for both result parts, registered.
// ----------------------------------------------------------------------------
module cfa_div_stage #(
  parameter int DW = 16,
  parameter int F  = 8,
  parameter int K  = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire logic [3*DW+F:0]    in_rem_re,
  input  wire logic [3*DW+F:0]    in_rem_im,
  input  wire logic [DW-1:0]      in_q_re,
  input  wire logic [DW-1:0]      in_q_im,
  input  wire logic [2*DW-1:0]    in_den,
  input  wire logic [4*DW+8:0]    in_side,
  output logic                    out_v,
  output logic [3*DW+F:0]         out_rem_re,
  output logic [3*DW+F:0]         out_rem_im,
  output logic [DW-1:0]           out_q_re,
  output logic [DW-1:0]           out_q_im,
  output logic [2*DW-1:0]         out_den,
  output logic [4*DW+8:0]         out_side
);
  localparam int XW = 3 * DW + F + 1;

  // shifted divisor and trial compares
  logic [XW-1:0] dk;
  logic          take_re, take_im;
  logic [DW-1:0] qbit;

  always_comb begin
    dk      = XW'(in_den) << K;
    take_re = (in_rem_re >= dk);
    take_im = (in_rem_im >= dk);
    qbit    = DW'(1) << K;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
    if (en) begin
      out_rem_re <= take_re ? in_rem_re - dk : in_rem_re;
      out_rem_im <= take_im ? in_rem_im - dk : in_rem_im;
      out_q_re   <= take_re ? (in_q_re | qbit) : in_q_re;
      out_q_im   <= take_im ? (in_q_im | qbit) : in_q_im;
      out_den    <= in_den;
      out_side   <= in_side;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cfa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_back
// Result select, sign, saturation, status and output register.
// ----------------------------------------------------------------------------
module cfa_back #(
  parameter int DW = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire logic [DW-1:0]      in_q_re,
  input  wire logic [DW-1:0]      in_q_im,
  input  wire logic [4*DW+8:0]    in_side,
  output logic                    out_v,
  output logic signed [DW-1:0]    out_re,
  output logic signed [DW-1:0]    out_im,
  output logic [1:0]              out_status
);
  localparam int SW = 2 * DW + 1;
  localparam logic [DW-1:0] HALF = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [SW-1:0] MAXV = SW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  // unpack side info
  cfa_pkg::cmd_t        cmd;
  logic                 div0, ovf_re, ovf_im, neg_re, neg_im;
  logic signed [SW-1:0] lin_re, lin_im;

  always_comb begin
    lin_im = in_side[SW-1:0];
    lin_re = in_side[2*SW-1:SW];
    neg_im = in_side[2*SW];
    neg_re = in_side[2*SW+1];
    ovf_im = in_side[2*SW+2];
    ovf_re = in_side[2*SW+3];
    div0   = in_side[2*SW+4];
    cmd    = cfa_pkg::cmd_t'(in_side[2*SW+6:2*SW+5]);
  end

  // saturate and pick result
  logic                  sat_re, sat_im;
  logic [DW-1:0]         re_next, im_next;
  cfa_pkg::status_t      status_next;

  always_comb begin
    sat_re = 1'b0;
    sat_im = 1'b0;
    if (cmd == cfa_pkg::OP_DIV) begin
      sat_re = ovf_re || (neg_re ? (in_q_re > HALF) : (in_q_re > HALF - DW'(1)));
      sat_im = ovf_im || (neg_im ? (in_q_im > HALF) : (in_q_im > HALF - DW'(1)));
      if (sat_re) begin
        re_next = neg_re ? HALF : ~HALF;
      end else begin
        re_next = neg_re ? (~in_q_re + DW'(1)) : in_q_re;
      end
      if (sat_im) begin
        im_next = neg_im ? HALF : ~HALF;
      end else begin
        im_next = neg_im ? (~in_q_im + DW'(1)) : in_q_im;
      end
    end else begin
      sat_re  = (lin_re > MAXV) || (lin_re < MINV);
      sat_im  = (lin_im > MAXV) || (lin_im < MINV);
      re_next = (lin_re > MAXV) ? ~HALF : (lin_re < MINV) ? HALF : lin_re[DW-1:0];
      im_next = (lin_im > MAXV) ? ~HALF : (lin_im < MINV) ? HALF : lin_im[DW-1:0];
    end
    if (cmd == cfa_pkg::OP_DIV && div0) begin
      re_next     = '0;
      im_next     = '0;
      status_next = cfa_pkg::ST_DIV0;
    end else if (sat_re || sat_im) begin
      status_next = cfa_pkg::ST_SAT;
    end else begin
      status_next = cfa_pkg::ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
    if (en) begin
      out_re     <= re_next;
      out_im     <= im_next;
      out_status <= status_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/complex_fixed_point_alu_core.sv
// Throughput: one beat per cycle; the pipeline advances whenever the output
// register is empty or its beat is taken, and holds as a whole otherwise.
// Divider: one restoring step per stage, DATA_WIDTH stages.
// Reset: synchronous, clears all valid bits; no memories, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_fixed_point_alu_core
// Pipelined complex add, subtract, multiply and divide on signed fixed point.
// ----------------------------------------------------------------------------
module complex_fixed_point_alu_core #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    cmd,
  input  wire logic signed [DATA_WIDTH-1:0]  a_re,
  input  wire logic signed [DATA_WIDTH-1:0]  a_im,
  input  wire logic signed [DATA_WIDTH-1:0]  b_re,
  input  wire logic signed [DATA_WIDTH-1:0]  b_im,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]       res_re,
  output logic signed [DATA_WIDTH-1:0]       res_im,
  output logic [1:0]                         status
);
  localparam int DW  = DATA_WIDTH;
  localparam int XW  = 3 * DW + FRAC_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int SDW = 4 * DW + 9;

  // global advance
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // divider chain taps
  logic          v    [0:DW];
  logic [XW-1:0] rre  [0:DW];
  logic [XW-1:0] rim  [0:DW];
  logic [DW-1:0] qre  [0:DW];
  logic [DW-1:0] qim  [0:DW];
  logic [PW-1:0] den  [0:DW];
  logic [SDW-1:0] side [0:DW];

  cfa_front #(.DW(DW), .F(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_v       (in_valid),
    .in_cmd     (cmd),
    .in_a       (a_re),
    .in_b       (a_im),
    .in_c       (b_re),
    .in_d       (b_im),
    .out_v      (v[0]),
    .out_rem_re (rre[0]),
    .out_rem_im (rim[0]),
    .out_den    (den[0]),
    .out_side   (side[0])
  );

  assign qre[0] = '0;
  assign qim[0] = '0;

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < DW; i++) begin : g_div
    cfa_div_stage #(.DW(DW), .F(FRAC_BITS), .K(DW - 1 - i)) u_stage (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .in_v       (v[i]),
      .in_rem_re  (rre[i]),
      .in_rem_im  (rim[i]),
      .in_q_re    (qre[i]),
      .in_q_im    (qim[i]),
      .in_den     (den[i]),
      .in_side    (side[i]),
      .out_v      (v[i+1]),
      .out_rem_re (rre[i+1]),
      .out_rem_im (rim[i+1]),
      .out_q_re   (qre[i+1]),
      .out_q_im   (qim[i+1]),
      .out_den    (den[i+1]),
      .out_side   (side[i+1])
    );
  end

  cfa_back #(.DW(DW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_v       (v[DW]),
    .in_q_re    (qre[DW]),
    .in_q_im    (qim[DW]),
    .in_side    (side[DW]),
    .out_v      (out_valid),
    .out_re     (res_re),
    .out_im     (res_im),
    .out_status (status)
  );

  // checks
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == cfa_pkg::ST_OK || status == cfa_pkg::ST_DIV0 ||
                   status == cfa_pkg::ST_SAT))
    else $error("status code out of range");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == cfa_pkg::ST_DIV0) |-> (res_re == '0 && res_im == '0))
    else $error("divide by zero result not zero");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("pipeline stalled without output backpressure");

endmodule
`default_nettype wire
